@@ design/sga_pkg.sv @@
// sga_pkg: shared widths, register indexes and types for the stick gesture
// arm/disarm block. No dependencies.
package sga_pkg;

  localparam int NUM_LANES = 4;
  localparam int VAL_W     = 12;
  localparam int HOLD_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

  // lane order within a frame
  localparam int LANE_THROTTLE = 0;
  localparam int LANE_YAW      = 1;
  localparam int LANE_ROLL     = 2;
  localparam int LANE_PITCH    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT   = 3'd6;

  localparam logic [VAL_W-1:0]  RST_LOW_END    = 12'd1000;
  localparam logic [VAL_W-1:0]  RST_HIGH_END   = 12'd2000;
  localparam logic [HOLD_W-1:0] RST_HOLD_COUNT = 16'd100;

  typedef logic [VAL_W-1:0]  value_t;
  typedef logic [HOLD_W-1:0] hold_t;

  typedef struct packed {
    logic toggle;
    logic arm_event;
    logic disarm_event;
  } merge_t;

endpackage

@@ design/sga_lane.sv @@
// sga_lane: one stick channel, window compare against its endpoint and the
// saturating hold counter. Depends on sga_pkg.
module sga_lane (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            clear,
  input  sga_pkg::value_t value,
  input  logic            valid,
  input  sga_pkg::value_t end_point,
  output sga_pkg::hold_t  hold_upd
);

  sga_pkg::hold_t  hold;
  sga_pkg::value_t diff;
  logic [sga_pkg::VAL_W+2:0] diff5;
  logic            match;

  always_comb begin
    diff  = (value >= end_point) ? (value - end_point) : (end_point - value);
    diff5 = ({3'b000, diff} << 2) + {3'b000, diff};
    match = diff5 <= {3'b000, end_point};
    if (!valid) begin
      hold_upd = hold;
    end else if (match) begin
      hold_upd = (hold == sga_pkg::HOLD_MAX) ? hold : hold + sga_pkg::hold_t'(1);
    end else begin
      hold_upd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (accept) begin
      hold <= clear ? '0 : hold_upd;
    end
  end

endmodule

@@ design/sga_merge.sv @@
// sga_merge: combines the four updated hold counters into the toggle decision
// and the arm or disarm event. Depends on sga_pkg.
module sga_merge (
  input  sga_pkg::hold_t holds [sga_pkg::NUM_LANES],
  input  sga_pkg::hold_t hold_count,
  input  logic           armed_flag,
  output sga_pkg::merge_t result
);

  logic [sga_pkg::NUM_LANES-1:0] reached;

  always_comb begin
    for (int i = 0; i < sga_pkg::NUM_LANES; i++) begin
      reached[i] = holds[i] >= hold_count;
    end
    result.toggle       = &reached;
    result.arm_event    = result.toggle && !armed_flag;
    result.disarm_event = result.toggle && armed_flag;
  end

endmodule

@@ design/stick_gesture_arm_disarm.sv @@
// stick_gesture_arm_disarm: top level, config registers, four channel lanes,
// merge stage and result register. Depends on sga_pkg, sga_lane, sga_merge.
// result: registered, valid in the cycle after the input transfer
// throughput: one frame per cycle while in_stall is low; the armed flag and hold
//   counters close a loop through the lanes and merge stage
// reset: synchronous, clears counters and armed flag, loads register defaults
module stick_gesture_arm_disarm (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] throttle_value,
  input  logic        throttle_valid,
  input  logic [11:0] yaw_value,
  input  logic        yaw_valid,
  input  logic [11:0] roll_value,
  input  logic        roll_valid,
  input  logic [11:0] pitch_value,
  input  logic        pitch_valid,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        armed,
  output logic        arm_event,
  output logic        disarm_event
);

  sga_pkg::value_t throttle_low_end, yaw_low_end, yaw_high_end;
  sga_pkg::value_t roll_low_end, roll_high_end, pitch_low_end;
  sga_pkg::hold_t  hold_count;
  logic            armed_flag;
  logic            accept;

  sga_pkg::value_t lane_value [sga_pkg::NUM_LANES];
  logic            lane_valid [sga_pkg::NUM_LANES];
  sga_pkg::value_t lane_end   [sga_pkg::NUM_LANES];
  sga_pkg::hold_t  lane_hold  [sga_pkg::NUM_LANES];
  sga_pkg::merge_t merged;

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_low_end <= sga_pkg::RST_LOW_END;
      yaw_low_end      <= sga_pkg::RST_LOW_END;
      yaw_high_end     <= sga_pkg::RST_HIGH_END;
      roll_low_end     <= sga_pkg::RST_LOW_END;
      roll_high_end    <= sga_pkg::RST_HIGH_END;
      pitch_low_end    <= sga_pkg::RST_LOW_END;
      hold_count       <= sga_pkg::RST_HOLD_COUNT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        sga_pkg::REG_THROTTLE_LOW: throttle_low_end <= cfg_data[sga_pkg::VAL_W-1:0];
        sga_pkg::REG_YAW_LOW:      yaw_low_end      <= cfg_data[sga_pkg::VAL_W-1:0];
        sga_pkg::REG_YAW_HIGH:     yaw_high_end     <= cfg_data[sga_pkg::VAL_W-1:0];
        sga_pkg::REG_ROLL_LOW:     roll_low_end     <= cfg_data[sga_pkg::VAL_W-1:0];
        sga_pkg::REG_ROLL_HIGH:    roll_high_end    <= cfg_data[sga_pkg::VAL_W-1:0];
        sga_pkg::REG_PITCH_LOW:    pitch_low_end    <= cfg_data[sga_pkg::VAL_W-1:0];
        sga_pkg::REG_HOLD_COUNT:   hold_count       <= cfg_data;
        default: ;
      endcase
    end
  end

  // a new frame may enter whenever the result register is free or drains
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    lane_value[sga_pkg::LANE_THROTTLE] = throttle_value;
    lane_value[sga_pkg::LANE_YAW]      = yaw_value;
    lane_value[sga_pkg::LANE_ROLL]     = roll_value;
    lane_value[sga_pkg::LANE_PITCH]    = pitch_value;
    lane_valid[sga_pkg::LANE_THROTTLE] = throttle_valid;
    lane_valid[sga_pkg::LANE_YAW]      = yaw_valid;
    lane_valid[sga_pkg::LANE_ROLL]     = roll_valid;
    lane_valid[sga_pkg::LANE_PITCH]    = pitch_valid;
    // arm gesture while disarmed, disarm gesture while armed
    lane_end[sga_pkg::LANE_THROTTLE]   = throttle_low_end;
    lane_end[sga_pkg::LANE_YAW]        = armed_flag ? yaw_low_end : yaw_high_end;
    lane_end[sga_pkg::LANE_ROLL]       = armed_flag ? roll_low_end : roll_high_end;
    lane_end[sga_pkg::LANE_PITCH]      = pitch_low_end;
  end

  for (genvar g = 0; g < sga_pkg::NUM_LANES; g++) begin : g_lane
    sga_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .clear     (merged.toggle),
      .value     (lane_value[g]),
      .valid     (lane_valid[g]),
      .end_point (lane_end[g]),
      .hold_upd  (lane_hold[g])
    );
  end

  sga_merge u_merge (
    .holds      (lane_hold),
    .hold_count (hold_count),
    .armed_flag (armed_flag),
    .result     (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag <= 1'b0;
    end else if (accept && merged.toggle) begin
      armed_flag <= !armed_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      armed        <= armed_flag ^ merged.toggle;
      arm_event    <= merged.arm_event;
      disarm_event <= merged.disarm_event;
    end
  end

endmodule

@@ design/sga_checker.sv @@
// sga_checker: port-level assertions for stick_gesture_arm_disarm, attached
// by the bind below. No package dependency.
module sga_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic armed,
  input logic arm_event,
  input logic disarm_event
);

  // a completed gesture must agree with the armed state it produced
  a_event_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(arm_event && disarm_event) && (!arm_event || armed)
                  && (!disarm_event || !armed))
    else $error("event does not match armed state");

  // every input transfer yields a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("input transfer without result");

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a pending result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(armed) && $stable(arm_event)
                                 && $stable(disarm_event))
    else $error("stalled result changed");

endmodule

bind stick_gesture_arm_disarm sga_checker u_sga_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .armed        (armed),
  .arm_event    (arm_event),
  .disarm_event (disarm_event)
);

@@ tb/sv/testbench.sv @@
// testbench for stick_gesture_arm_disarm: drives radio frames and config writes,
// predicts armed state and gesture events, checks every result transfer.
// depends on sga_pkg and the design sources.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VAL_MAX = (1 << sga_pkg::VAL_W) - 1;
  // endpoint registers sit below the hold count register
  localparam int NUM_ENDS = int'(sga_pkg::REG_HOLD_COUNT);
  localparam logic [sga_pkg::CFG_IDX_W-1:0] REG_NONE = sga_pkg::REG_HOLD_COUNT + 1'b1;
  localparam logic [sga_pkg::NUM_LANES-1:0] ALL_LANES = '1;
  localparam logic [sga_pkg::NUM_LANES-1:0] NO_LANES = '0;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int PHASE_FRAMES = 95;

  typedef struct packed {
    sga_pkg::value_t [sga_pkg::NUM_LANES-1:0] val;
    logic [sga_pkg::NUM_LANES-1:0]            vld;
  } frame_t;

  typedef struct packed {
    logic armed;
    logic arm_event;
    logic disarm_event;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [sga_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sga_pkg::CFG_DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  frame_t in_frame = '0;
  logic out_valid;
  logic stall_rand = 1'b0;
  logic hold_off = 1'b0;
  logic out_stall;
  logic armed, arm_event, disarm_event;

  int gap_pct = 0;
  int stall_pct = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  event hold_off_go;

  // predicted block state
  sga_pkg::value_t ep_reg [NUM_ENDS];
  sga_pkg::hold_t hold_lim;
  sga_pkg::hold_t hold_cnt [sga_pkg::NUM_LANES];
  logic armed_now;
  status_t pending_status [$];

  assign out_stall = stall_rand | hold_off;

  stick_gesture_arm_disarm dut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .throttle_value(in_frame.val[sga_pkg::LANE_THROTTLE]),
    .throttle_valid(in_frame.vld[sga_pkg::LANE_THROTTLE]),
    .yaw_value(in_frame.val[sga_pkg::LANE_YAW]),
    .yaw_valid(in_frame.vld[sga_pkg::LANE_YAW]),
    .roll_value(in_frame.val[sga_pkg::LANE_ROLL]),
    .roll_valid(in_frame.vld[sga_pkg::LANE_ROLL]),
    .pitch_value(in_frame.val[sga_pkg::LANE_PITCH]),
    .pitch_valid(in_frame.vld[sga_pkg::LANE_PITCH]),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .armed(armed),
    .arm_event(arm_event),
    .disarm_event(disarm_event)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // endpoint a lane is compared against in the current arming state
  function automatic sga_pkg::value_t lane_end(int lane);
    case (lane)
      sga_pkg::LANE_THROTTLE: return ep_reg[sga_pkg::REG_THROTTLE_LOW];
      sga_pkg::LANE_YAW:
        return armed_now ? ep_reg[sga_pkg::REG_YAW_LOW] : ep_reg[sga_pkg::REG_YAW_HIGH];
      sga_pkg::LANE_ROLL:
        return armed_now ? ep_reg[sga_pkg::REG_ROLL_LOW] : ep_reg[sga_pkg::REG_ROLL_HIGH];
      default: return ep_reg[sga_pkg::REG_PITCH_LOW];
    endcase
  endfunction

  // within 20 percent: 5 * |value - end| <= end
  function automatic bit near_end(sga_pkg::value_t v, sga_pkg::value_t ep);
    int d;
    d = (v >= ep) ? int'(v) - int'(ep) : int'(ep) - int'(v);
    return d * 5 <= int'(ep);
  endfunction

  function automatic void predict_gesture(frame_t f);
    status_t s;
    bit all_held;
    for (int i = 0; i < sga_pkg::NUM_LANES; i++) begin
      if (f.vld[i]) begin
        if (!near_end(f.val[i], lane_end(i)))
          hold_cnt[i] = '0;
        else if (hold_cnt[i] != sga_pkg::HOLD_MAX)
          hold_cnt[i]++;
      end
    end
    // the toggle test runs on every frame, valid lanes or not
    all_held = 1'b1;
    for (int i = 0; i < sga_pkg::NUM_LANES; i++)
      if (hold_cnt[i] < hold_lim) all_held = 1'b0;
    s = '0;
    if (all_held) begin
      s.arm_event = !armed_now;
      s.disarm_event = armed_now;
      armed_now = !armed_now;
      for (int i = 0; i < sga_pkg::NUM_LANES; i++) hold_cnt[i] = '0;
    end
    s.armed = armed_now;
    pending_status.push_back(s);
  endfunction

  function automatic void check_bit(string name, logic want, logic got);
    if (got !== want) begin
      fault_count++;
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : score
    status_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_status.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result armed %0b arm_event %0b disarm_event %0b",
                   $time, armed, arm_event, disarm_event);
        end else begin
          want = pending_status.pop_front();
          check_bit("armed", want.armed, armed);
          check_bit("arm_event", want.arm_event, arm_event);
          check_bit("disarm_event", want.disarm_event, disarm_event);
        end
      end
      if (cfg_wen) begin
        if (cfg_index == sga_pkg::REG_HOLD_COUNT)
          hold_lim = cfg_data;
        else if (cfg_index <= sga_pkg::REG_PITCH_LOW)
          ep_reg[cfg_index] = cfg_data[sga_pkg::VAL_W-1:0];
      end
      if (in_valid && !in_stall) predict_gesture(in_frame);
    end
  end

  always @(negedge clk) stall_rand <= ($urandom_range(99) < stall_pct);

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_off_go);
      @(negedge clk);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clk);
      hold_off <= 1'b0;
    end
  end

  // all tasks below start and end at a falling edge
  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_frame <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [sga_pkg::CFG_IDX_W-1:0] idx,
                           logic [sga_pkg::CFG_DAT_W-1:0] data);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic frame_t mk_frame(sga_pkg::value_t t, sga_pkg::value_t y,
                                      sga_pkg::value_t r, sga_pkg::value_t p,
                                      logic [sga_pkg::NUM_LANES-1:0] vld);
    frame_t f;
    f.val[sga_pkg::LANE_THROTTLE] = t;
    f.val[sga_pkg::LANE_YAW] = y;
    f.val[sga_pkg::LANE_ROLL] = r;
    f.val[sga_pkg::LANE_PITCH] = p;
    f.vld = vld;
    return f;
  endfunction

  // every lane sits exactly on its current gesture endpoint
  function automatic frame_t gesture_frame(logic [sga_pkg::NUM_LANES-1:0] vld);
    frame_t f;
    for (int i = 0; i < sga_pkg::NUM_LANES; i++) f.val[i] = lane_end(i);
    f.vld = vld;
    return f;
  endfunction

  // mostly inside the window, some right on its edge or just past it
  function automatic sga_pkg::value_t aim_value(sga_pkg::value_t ep);
    int c, w, v, pick;
    c = int'(ep);
    w = c / 5;
    pick = $urandom_range(99);
    if (pick < 70) v = c - w + int'($urandom_range(2 * w));
    else if (pick < 80) v = $urandom_range(1) ? c - w : c + w;
    else if (pick < 90) v = $urandom_range(1) ? c - w - 1 : c + w + 1;
    else v = $urandom_range(VAL_MAX);
    if (v < 0) v = 0;
    else if (v > VAL_MAX) v = VAL_MAX;
    return sga_pkg::value_t'(v);
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    bit noise;
    noise = ($urandom_range(99) < 15);
    for (int i = 0; i < sga_pkg::NUM_LANES; i++) begin
      f.vld[i] = noise ? 1'($urandom_range(1)) : ($urandom_range(99) < 90);
      f.val[i] = noise ? sga_pkg::value_t'($urandom_range(VAL_MAX))
                       : aim_value(lane_end(i));
    end
    return f;
  endfunction

  task automatic test_idle_frame();
    send_frame(mk_frame('0, '0, '0, '0, NO_LANES));
  endtask

  task automatic test_window_edges();
    settle();
    write_reg(sga_pkg::REG_HOLD_COUNT, 16'd1);
    send_frame(mk_frame(12'd799, 12'd2400, 12'd1600, 12'd1200, ALL_LANES));
    send_frame(mk_frame(12'd800, 12'd2401, 12'd1600, 12'd1200, ALL_LANES));
    send_frame(mk_frame(12'd1200, 12'd2400, 12'd1600, 12'd800, ALL_LANES));
    send_frame(mk_frame(12'd1000, 12'd800, 12'd1200, 12'd1000, ALL_LANES));
  endtask

  task automatic test_endpoint_extremes();
    settle();
    for (int r = 0; r < NUM_ENDS; r++) write_reg(sga_pkg::CFG_IDX_W'(r), '0);
    // zero endpoint: only a zero value matches
    send_frame(mk_frame('0, '0, '0, 12'd1, ALL_LANES));
    send_frame(mk_frame('0, '0, '0, '0, ALL_LANES));
    settle();
    for (int r = 0; r < NUM_ENDS; r++)
      write_reg(sga_pkg::CFG_IDX_W'(r), sga_pkg::CFG_DAT_W'(VAL_MAX));
    send_frame(mk_frame(12'd4095, 12'd3276, 12'd3275, 12'd4095, ALL_LANES));
    send_frame(mk_frame(12'd3276, 12'd4095, 12'd4095, 12'd4095, ALL_LANES));
  endtask

  task automatic test_hold_and_invalid();
    settle();
    // upper data bits are dropped on the 12-bit registers
    write_reg(sga_pkg::REG_THROTTLE_LOW, 16'hF3E8);
    write_reg(sga_pkg::REG_YAW_LOW, 16'hA3E8);
    write_reg(sga_pkg::REG_YAW_HIGH, 16'h57D0);
    write_reg(sga_pkg::REG_ROLL_LOW, 16'h13E8);
    write_reg(sga_pkg::REG_ROLL_HIGH, 16'hC7D0);
    write_reg(sga_pkg::REG_PITCH_LOW, 16'h33E8);
    write_reg(sga_pkg::REG_HOLD_COUNT, 16'd2);
    write_reg(REG_NONE, 16'd1);
    send_frame(gesture_frame(ALL_LANES));
    // an invalid lane keeps its count
    send_frame(gesture_frame(~(sga_pkg::NUM_LANES'(1) << sga_pkg::LANE_THROTTLE)));
    send_frame(gesture_frame(ALL_LANES));
    send_frame(gesture_frame(NO_LANES));
  endtask

  task automatic test_hold_zero();
    settle();
    write_reg(sga_pkg::REG_HOLD_COUNT, '0);
    send_frame(mk_frame('0, '0, '0, '0, NO_LANES));
    send_frame(mk_frame('0, '0, '0, '0, NO_LANES));
    send_frame(mk_frame('0, '0, '0, '0, ALL_LANES));
  endtask

  task automatic test_backpressure();
    settle();
    gap_pct = 0;
    stall_pct = 0;
    -> hold_off_go;
    repeat (40) send_frame(random_frame());
    // sender pauses until every result is back
    settle();
    gap_pct = 38;
    stall_pct = 38;
    repeat (40) send_frame(random_frame());
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      for (int r = 0; r < NUM_ENDS; r++) begin
        if (ph == 2) write_reg(sga_pkg::CFG_IDX_W'(r), sga_pkg::CFG_DAT_W'(VAL_MAX));
        else if (ph == 5) write_reg(sga_pkg::CFG_IDX_W'(r), '0);
        else write_reg(sga_pkg::CFG_IDX_W'(r), sga_pkg::CFG_DAT_W'($urandom));
      end
      if (ph == 2) write_reg(sga_pkg::REG_HOLD_COUNT, 16'd2);
      else if (ph == 5) write_reg(sga_pkg::REG_HOLD_COUNT, 16'd1);
      else write_reg(sga_pkg::REG_HOLD_COUNT, sga_pkg::CFG_DAT_W'($urandom_range(6, 1)));
      repeat (PHASE_FRAMES) send_frame(random_frame());
    end
  endtask

  initial begin
    ep_reg[sga_pkg::REG_THROTTLE_LOW] = sga_pkg::RST_LOW_END;
    ep_reg[sga_pkg::REG_YAW_LOW] = sga_pkg::RST_LOW_END;
    ep_reg[sga_pkg::REG_YAW_HIGH] = sga_pkg::RST_HIGH_END;
    ep_reg[sga_pkg::REG_ROLL_LOW] = sga_pkg::RST_LOW_END;
    ep_reg[sga_pkg::REG_ROLL_HIGH] = sga_pkg::RST_HIGH_END;
    ep_reg[sga_pkg::REG_PITCH_LOW] = sga_pkg::RST_LOW_END;
    hold_lim = sga_pkg::RST_HOLD_COUNT;
    armed_now = 1'b0;
    for (int i = 0; i < sga_pkg::NUM_LANES; i++) hold_cnt[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_frame();
    test_window_edges();
    test_endpoint_extremes();
    test_hold_and_invalid();
    test_hold_zero();
    test_backpressure();
    test_random_phases();

    settle();
    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ stick_gesture_arm_disarm.f @@
design/sga_pkg.sv
design/sga_lane.sv
design/sga_merge.sv
design/stick_gesture_arm_disarm.sv
design/sga_checker.sv
tb/sv/testbench.sv
